// File: design/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg: shared definitions for the radix digit converter
// Widths, codes, controller/datapath interface types, digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package brd_pkg;

    // Fixed field widths
    localparam int VALUE_PORT_W = 64;
    localparam int RADIX_W      = 6;
    localparam int DIGIT_W      = 6;
    localparam int CHAR_W       = 7;

    // Parameter defaults
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int DIGIT_SLOTS_DEF = 64;

    // Base limits and reset base
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // ASCII mapping
    localparam logic [DIGIT_W-1:0] DEC_DIGITS     = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO      = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_A_OFFSET  = 7'd87;  // 'a' - 10
    localparam logic [CHAR_W-1:0]  CHAR_BAD       = 7'd0;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;       // load value, clear write pointer and digit count
        logic div_step;    // one restoring division bit
        logic rd_issue;    // read digit store at read pointer
        logic load_bad;    // load bad-base item into output register
        logic load_digit;  // load next digit item into output register
    } brd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic radix_bad;   // configured base outside 2..36
        logic div_done;    // current step finishes one digit
        logic quot_zero;   // quotient after this step is zero
        logic out_free;    // output register can take an item this cycle
        logic last_digit;  // next emitted digit is the final one
    } brd_stat_t;

    // Digit value to ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < DEC_DIGITS)
            digit_char = CHAR_ZERO + dx;
        else if (d < RADIX_MAX)
            digit_char = CHAR_A_OFFSET + dx;
        else
            digit_char = CHAR_BAD;
    endfunction

endpackage

// File: design/brd_ctrl.sv
// ----------------------------------------------------------------------------
// brd_ctrl: conversion sequencer
// Steps the divider until the quotient reaches zero, then emits stored digits; a bad base gives one bad-base item.
// ----------------------------------------------------------------------------
module brd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  brd_pkg::brd_stat_t stat,
    output brd_pkg::brd_cmd_t  cmd
);
    import brd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ERR  = 5'b00010,
        S_DIV  = 5'b00100,
        S_RD   = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.radix_bad)
                        state_next = S_ERR;
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_bad = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done && stat.quot_zero)
                    state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    state_next     = stat.last_digit ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: design/brd_dpath.sv
// ----------------------------------------------------------------------------
// brd_dpath: divider, digit store and output register
// Radix-2 restoring division by the base, circular digit store, item output.
// ----------------------------------------------------------------------------
module brd_dpath #(
    parameter int VALUE_WIDTH = brd_pkg::VALUE_WIDTH_DEF,
    parameter int DIGIT_SLOTS = brd_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [brd_pkg::VALUE_PORT_W-1:0]  value,
    input  logic                              cfg_valid,
    input  logic [brd_pkg::RADIX_W-1:0]       radix,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [brd_pkg::CHAR_W-1:0]        char_code,
    output logic                              last,
    output logic                              bad_radix,
    input  brd_pkg::brd_cmd_t                 cmd,
    output brd_pkg::brd_stat_t                stat
);
    import brd_pkg::*;

    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int AW = $clog2(DIGIT_SLOTS);
    localparam int CW = $clog2(DIGIT_SLOTS + 1);
    localparam logic [BW-1:0] BIT_LAST  = BW'(VALUE_WIDTH - 1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(DIGIT_SLOTS - 1);
    localparam logic [CW-1:0] SLOT_FULL = CW'(DIGIT_SLOTS);
    localparam logic [CW-1:0] ONE_LEFT  = CW'(1);

    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [AW-1:0]          rp_reg, rp_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          left_reg, left_next;
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   bad_reg, bad_next;
    logic                   out_valid_reg, out_valid_next;

    logic [DIGIT_W-1:0]     digit_mem [DIGIT_SLOTS];

    logic [DIGIT_W:0]       trial;
    logic                   ge;
    logic [DIGIT_W-1:0]     rem_step;
    logic [VALUE_WIDTH-1:0] quot_step;
    logic                   div_done;
    logic                   mem_we;
    logic [AW-1:0]          wp_inc;
    logic [AW-1:0]          rp_dec;
    logic [CW-1:0]          cnt_inc;

    // One restoring division bit
    always_comb
    begin
        trial     = {rem_reg, quot_reg[VALUE_WIDTH-1]};
        ge        = trial >= {1'b0, radix_reg};
        rem_step  = ge ? DIGIT_W'(trial - {1'b0, radix_reg}) : trial[DIGIT_W-1:0];
        quot_step = {quot_reg[VALUE_WIDTH-2:0], ge};
        div_done  = bit_cnt_reg == BIT_LAST;
        mem_we    = cmd.div_step && div_done;
    end

    // Pointer arithmetic, wrapping at the slot count
    always_comb
    begin
        wp_inc  = (wp_reg == SLOT_LAST) ? '0 : wp_reg + 1'b1;
        rp_dec  = (rp_reg == '0) ? SLOT_LAST : rp_reg - 1'b1;
        cnt_inc = (cnt_reg == SLOT_FULL) ? cnt_reg : cnt_reg + 1'b1;
    end

    // Next values
    always_comb
    begin
        radix_next     = radix_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid)
            radix_next = radix;

        if (cmd.start)
        begin
            quot_next    = value[VALUE_WIDTH-1:0];
            rem_next     = '0;
            bit_cnt_next = '0;
            wp_next      = '0;
            cnt_next     = '0;
        end

        if (cmd.div_step)
        begin
            quot_next = quot_step;
            if (div_done)
            begin
                // digit complete: store it, restart for the next one
                rem_next     = '0;
                bit_cnt_next = '0;
                wp_next      = wp_inc;
                rp_next      = wp_reg;
                cnt_next     = cnt_inc;
                left_next    = cnt_inc;
            end
            else
            begin
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
        end

        // Emission walks back from the most significant digit
        if (cmd.load_digit)
        begin
            rp_next        = rp_dec;
            left_next      = left_reg - 1'b1;
            char_next      = digit_char(rd_data_reg);
            last_next      = left_reg == ONE_LEFT;
            bad_next       = 1'b0;
            out_valid_next = 1'b1;
        end

        if (cmd.load_bad)
        begin
            char_next      = CHAR_BAD;
            last_next      = 1'b1;
            bad_next       = 1'b1;
            out_valid_next = 1'b1;
        end
    end

    // Control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            quot_reg      <= '0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            radix_reg     <= radix_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            bit_cnt_reg   <= bit_cnt_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    // Digit store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[wp_reg] <= rem_step;
        if (cmd.rd_issue)
            rd_data_reg <= digit_mem[rp_reg];
    end

    // Status
    always_comb
    begin
        stat.radix_bad  = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
        stat.div_done   = div_done;
        stat.quot_zero  = quot_step == '0;
        stat.out_free   = !out_valid_reg || out_ready;
        stat.last_digit = left_reg == ONE_LEFT;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;

endmodule

// File: design/binary_to_radix_digits.sv
// Sequence: the divider produces the digits in turn, then each stored digit is
//   read (S_RD) and loaded into the output register (S_OUT) once the output is free.
// Throughput: one item at a time; the one-bit-per-cycle divider sets the rate.
// A bad base gives its single item through the S_ERR state and the output register.
// Reset (async, active low): controller idle, base 10, output empty;
//   the digit store is not cleared.
// ----------------------------------------------------------------------------
// binary_to_radix_digits: unsigned value to ASCII digits in a configured base
// Emits digits most significant first, last flag on the final one.
// ----------------------------------------------------------------------------
module binary_to_radix_digits #(
    parameter int VALUE_WIDTH = brd_pkg::VALUE_WIDTH_DEF,
    parameter int DIGIT_SLOTS = brd_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brd_pkg::RADIX_W-1:0]       radix,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [brd_pkg::VALUE_PORT_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [brd_pkg::CHAR_W-1:0]        char_code,
    output logic                              last,
    output logic                              bad_radix
);
    import brd_pkg::*;

    brd_cmd_t  cmd;
    brd_stat_t stat;

    // Base register is always writable
    assign cfg_ready = 1'b1;

    brd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brd_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cfg_valid (cfg_valid),
        .radix     (radix),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .char_code (char_code),
        .last      (last),
        .bad_radix (bad_radix),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: design/brd_checker.sv
// ----------------------------------------------------------------------------
// brd_checker: port-level checks for the radix digit converter
// Watches handshakes and emitted items; attached to the top level by bind.
// ----------------------------------------------------------------------------
module brd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [brd_pkg::CHAR_W-1:0]        char_code,
    input logic                              last,
    input logic                              bad_radix
);
    import brd_pkg::*;

    // A stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code)
            && $stable(last) && $stable(bad_radix))
        else $error("output item changed while stalled");

    // Bad-base item is a single terminated null character
    a_bad_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_radix |-> last && (char_code == CHAR_BAD))
        else $error("bad-base item malformed");

    // Good-base items are digit characters only
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_radix |->
            ((char_code >= 7'd48) && (char_code <= 7'd57))
            || ((char_code >= 7'd97) && (char_code <= 7'd122)))
        else $error("digit character out of range");

    // One conversion at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a conversion runs");

endmodule

bind binary_to_radix_digits brd_checker u_brd_checker (.*);

// File: bench/tb_binary_to_radix_digits.sv
// ----------------------------------------------------------------------------
// tb_binary_to_radix_digits: self-checking bench for the radix digit converter
// A table of directed values runs first, then random values over several bases,
// good and bad. Every output item is checked against a typed expectation or a
// digit predictor. Both sides of the handshake stall at random outside steady-flow phases.
// ----------------------------------------------------------------------------
module tb_binary_to_radix_digits;

    import brd_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          DIGIT_LIMIT   = 64;     // digit slots of the block
    localparam int          IDLE_LIMIT    = 20000;  // cycles with no handshake at all
    localparam int          SETTLE_CYCLES = 20;
    localparam int          PHASE_ITEMS   = 11;
    localparam logic [6:0]  ASCII_ZERO    = 7'h30;
    localparam logic [6:0]  ASCII_LOWER_A = 7'h61;
    localparam logic [6:0]  NO_CHAR       = 7'h00;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    // One output item: a digit character and its flags
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              lst;
        logic              bad;
    } digit_item_t;

    // One directed row: base, value, and a typed result where it is obvious
    typedef struct packed {
        logic [RADIX_W-1:0]      base;
        logic [VALUE_PORT_W-1:0] val;
        logic                    typed;
        logic [CHAR_W-1:0]       ch;
        logic                    lst;
        logic                    bad;
    } vector_row_t;

    localparam int NUM_ROWS = 21;

    vector_row_t directed_rows [NUM_ROWS] = '{
        '{6'd10, 64'd0,                   1'b1, 7'h30,   1'b1, 1'b0},  // zero gives '0'
        '{6'd10, 64'd9,                   1'b1, 7'h39,   1'b1, 1'b0},
        '{6'd10, ALL_ONES,                1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd10, 64'd1234567890,          1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd2,  64'd0,                   1'b1, 7'h30,   1'b1, 1'b0},
        '{6'd2,  64'd1,                   1'b1, 7'h31,   1'b1, 1'b0},
        '{6'd2,  ALL_ONES,                1'b0, NO_CHAR, 1'b0, 1'b0},  // 64 digits
        '{6'd2,  64'h8000_0000_0000_0000, 1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd36, 64'd35,                  1'b1, 7'h7a,   1'b1, 1'b0},  // 'z'
        '{6'd36, 64'd36,                  1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd36, ALL_ONES,                1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd16, 64'd10,                  1'b1, 7'h61,   1'b1, 1'b0},  // 'a'
        '{6'd16, 64'hFEDC_BA98_7654_3210, 1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd0,  64'd5,                   1'b1, NO_CHAR, 1'b1, 1'b1},  // bad bases
        '{6'd1,  64'd0,                   1'b1, NO_CHAR, 1'b1, 1'b1},
        '{6'd37, 64'd1,                   1'b1, NO_CHAR, 1'b1, 1'b1},
        '{6'd63, ALL_ONES,                1'b1, NO_CHAR, 1'b1, 1'b1},
        '{6'd3,  ALL_ONES,                1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd35, 64'd34,                  1'b1, 7'h79,   1'b1, 1'b0},  // 'y'
        '{6'd8,  64'h5555_5555_5555_5555, 1'b0, NO_CHAR, 1'b0, 1'b0},
        '{6'd10, 64'd10,                  1'b0, NO_CHAR, 1'b0, 1'b0}
    };

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [RADIX_W-1:0]      radix     = RADIX_RESET;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [VALUE_PORT_W-1:0] value     = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [CHAR_W-1:0]       char_code;
    logic                    last;
    logic                    bad_radix;

    digit_item_t        pending_digits [$];
    logic [RADIX_W-1:0] model_radix    = RADIX_RESET;
    int                 mismatch_count = 0;
    int                 idle_cycles    = 0;
    bit                 steady_flow    = 1'b0;

    binary_to_radix_digits u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .radix     (radix),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last),
        .bad_radix (bad_radix)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: any handshake clears the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int draw_gap();
        if (steady_flow)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Divide by the base until zero, then queue characters MSB first; a bad base queues one bad item
    function automatic void predict_digits(input logic [63:0] v);
        logic [63:0] quot;
        logic [63:0] base;
        logic [5:0]  rems [DIGIT_LIMIT];
        logic [5:0]  d;
        int          n;
        digit_item_t item;

        base = {58'd0, model_radix};
        if (model_radix < 6'd2 || model_radix > 6'd36)
        begin
            item = '{ch: NO_CHAR, lst: 1'b1, bad: 1'b1};
            pending_digits.push_back(item);
            return;
        end
        quot = v;
        n    = 0;
        do
        begin
            if (n < DIGIT_LIMIT)
            begin
                rems[n] = 6'(quot % base);
                n++;
            end
            else
            begin
                // keep only the most significant digits
                for (int i = 0; i < DIGIT_LIMIT - 1; i++)
                    rems[i] = rems[i + 1];
                rems[DIGIT_LIMIT - 1] = 6'(quot % base);
            end
            quot = quot / base;
        end
        while (quot != 64'd0);

        for (int k = 0; k < n; k++)
        begin
            d = rems[n - 1 - k];
            if (d < 6'd10)
                item.ch = ASCII_ZERO + {1'b0, d};
            else
                item.ch = ASCII_LOWER_A + {1'b0, d} - 7'd10;
            item.lst = (k == n - 1);
            item.bad = 1'b0;
            pending_digits.push_back(item);
        end
    endfunction

    // Send one value; typed rows supply their own single expected item
    task automatic send_value(input logic [63:0] v, input bit typed, input digit_item_t typed_item);
        int gap;

        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        if (typed)
            pending_digits.push_back(typed_item);
        else
            predict_digits(v);
    endtask

    // Hold the sender until every expected item is out and the block is idle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_drained();
        cfg_valid <= 1'b1;
        radix     <= r;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        model_radix = r;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] wide;

        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return wide;
            1: return 64'($urandom_range(0, 99));
            2: return 64'd1 << $urandom_range(0, 63);
            3: return ALL_ONES >> $urandom_range(0, 63);
            4: return wide >> $urandom_range(0, 63);
            default: return ALL_ONES - 64'($urandom_range(0, 3));
        endcase
    endfunction

    // Output side: random stall per item, then compare with the oldest expectation
    initial
    begin
        int          stall;
        digit_item_t want;

        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_digits.size() == 0)
                report_mismatch($sformatf("unexpected item char=%h last=%b bad=%b",
                                          char_code, last, bad_radix));
            else
            begin
                want = pending_digits.pop_front();
                if (char_code !== want.ch)
                    report_mismatch($sformatf("char_code %h, want %h", char_code, want.ch));
                if (last !== want.lst)
                    report_mismatch($sformatf("last %b, want %b", last, want.lst));
                if (bad_radix !== want.bad)
                    report_mismatch($sformatf("bad_radix %b, want %b", bad_radix, want.bad));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain
    initial
    begin
        int                 phase_radix [10];
        digit_item_t        row_item;
        logic [RADIX_W-1:0] r;

        phase_radix = '{10, 2, 36, 16, 0, 7, 37, 63, -1, -2};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; base changes only between items with the block idle
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].base != model_radix)
                write_radix(directed_rows[i].base);
            row_item = '{ch: directed_rows[i].ch, lst: directed_rows[i].lst,
                         bad: directed_rows[i].bad};
            send_value(directed_rows[i].val, directed_rows[i].typed, row_item);
        end

        // Random phases; -1 picks a good base, -2 any base
        for (int p = 0; p < 10; p++)
        begin
            if (phase_radix[p] == -1)
                r = 6'($urandom_range(2, 36));
            else if (phase_radix[p] == -2)
                r = 6'($urandom_range(0, 63));
            else
                r = 6'(phase_radix[p]);
            write_radix(r);
            steady_flow = (p % 3 == 2);
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                if (j == PHASE_ITEMS / 2)
                    wait_drained();
                send_value(random_value(), 1'b0, row_item);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
